// ----- rtl/core/ufc_pkg.sv -----
// Shared types and fixed constants for the union-find cycle checker.
// No dependencies; every other file in rtl/core imports this package.
package ufc_pkg;

  localparam int IN_W    = 10;  // endpoint field width
  localparam int COUNT_W = 11;  // node count and edge count width
  localparam int RANK_W  = 4;   // rank entry width

  localparam logic [COUNT_W-1:0] EDGE_MAX       = 11'd2047;
  localparam logic [RANK_W-1:0]  RANK_MAX       = 4'd15;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic already_joined;
    logic cycle_seen;
    logic is_tree;
  } res_t;

endpackage

// ----- rtl/core/ufc_tally.sv -----
// Cycle flag, saturating edge count and node_count register; forms the result flags.
// Depends on ufc_pkg.
module ufc_tally
  import ufc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               upd,
  input  logic               joined,
  output res_t               res
);

  logic [COUNT_W-1:0] node_count;
  logic               cycle_flag;
  logic [COUNT_W-1:0] edges_taken;

  logic               cycle_flag_next;
  logic [COUNT_W-1:0] edges_taken_next;
  logic [COUNT_W:0]   edges_plus_one;

  always_comb begin
    cycle_flag_next  = cycle_flag | joined;
    edges_taken_next = (edges_taken == EDGE_MAX) ? edges_taken
                                                 : edges_taken + COUNT_W'(1);
    edges_plus_one   = (COUNT_W+1)'(edges_taken_next) + (COUNT_W+1)'(1);
    res.already_joined = joined;
    res.cycle_seen     = cycle_flag_next;
    res.is_tree        = !cycle_flag_next
                         && (edges_plus_one == (COUNT_W+1)'(node_count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      cycle_flag  <= 1'b0;
      edges_taken <= '0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (upd) begin
        cycle_flag  <= cycle_flag_next;
        edges_taken <= edges_taken_next;
      end
    end
  end

endmodule

// ----- rtl/core/union_find_cycle_check_top.sv -----
// Top level of the union-find cycle checker: sequencer, parent and rank memories.
// Depends on ufc_pkg and ufc_tally.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   in       | in_valid / in_ready     | node_a, node_b
//   out      | out_valid / out_ready   | already_joined, cycle_seen, is_tree
//   cfg      | cfg_wr_en (no wait)     | cfg_wr_data (node_count)
//
// After reset a clearing pass sets every parent to its own index and every rank to
// zero; in_ready stays low meanwhile, cfg writes are taken.
// An edge goes from its transfer through the fold, both root walks, the rank read
// and the join step until its result is registered. The fold subtracts NODES from
// an endpoint while it is >= NODES; each path-halving step reads the parent, then
// the grandparent, and relinks the node to it. A held result stalls the join step.
module union_find_cycle_check_top
  import ufc_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_W-1:0]    node_a,
  input  logic [IN_W-1:0]    node_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               already_joined,
  output logic               cycle_seen,
  output logic               is_tree
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
  localparam logic [IN_W-1:0]  NODES_LO = IN_W'(NODES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_PAR   = 3'd3;
  localparam logic [2:0] S_GRAND = 3'd4;
  localparam logic [2:0] S_RANK  = 3'd5;
  localparam logic [2:0] S_JOIN  = 3'd6;

  // Forest storage
  logic [IDX_W-1:0]  parent_mem [NODES];
  logic [RANK_W-1:0] rank_mem   [NODES];
  logic [IDX_W-1:0]  par_rdata;
  logic [RANK_W-1:0] rank_rdata;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  clr_idx;
  logic [IN_W-1:0]   a_work, a_work_next;
  logic [IN_W-1:0]   b_work, b_work_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W-1:0]  ra, ra_next;
  logic [IDX_W-1:0]  rb, rb_next;
  logic [RANK_W-1:0] rank_b;
  logic              phase, phase_next;

  logic              par_we;
  logic [IDX_W-1:0]  par_waddr, par_wdata, par_raddr;
  logic              rank_we;
  logic [IDX_W-1:0]  rank_waddr, rank_raddr;
  logic [RANK_W-1:0] rank_wdata;

  logic              a_big, b_big;
  logic              joined;
  logic              join_go;
  res_t              res;

  assign in_ready = (state == S_IDLE);
  assign a_big    = (32'(a_work) >= NODES);
  assign b_big    = (32'(b_work) >= NODES);
  assign joined   = (ra == rb);
  // Drop into the join only when the output register is free or being drained
  assign join_go  = (state == S_JOIN) && (!out_valid || out_ready);

  assign rank_raddr = (state == S_RANK || state == S_JOIN) ? ra : cur;

  always_comb begin
    state_next  = state;
    a_work_next = a_work;
    b_work_next = b_work;
    cur_next    = cur;
    ra_next     = ra;
    rb_next     = rb;
    phase_next  = phase;
    par_raddr   = cur;
    par_we      = 1'b0;
    par_waddr   = cur;
    par_wdata   = cur;
    rank_we     = 1'b0;
    rank_waddr  = ra;
    rank_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        par_we     = 1'b1;
        par_waddr  = clr_idx;
        par_wdata  = clr_idx;
        rank_we    = 1'b1;
        rank_waddr = clr_idx;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          a_work_next = node_a;
          b_work_next = node_b;
          state_next  = S_FOLD;
        end
      end
      S_FOLD: begin
        // Fold endpoints into range with the shared subtractor, one per cycle
        if (a_big) begin
          a_work_next = a_work - NODES_LO;
        end else if (b_big) begin
          b_work_next = b_work - NODES_LO;
        end else begin
          cur_next   = IDX_W'(a_work);
          par_raddr  = IDX_W'(a_work);
          phase_next = 1'b0;
          state_next = S_PAR;
        end
      end
      S_PAR: begin
        if (par_rdata == cur) begin
          if (!phase) begin
            ra_next    = cur;
            cur_next   = IDX_W'(b_work);
            par_raddr  = IDX_W'(b_work);
            phase_next = 1'b1;
          end else begin
            rb_next    = cur;
            state_next = S_RANK;
          end
        end else begin
          // Fetch the grandparent; cur keeps the node to relink
          par_raddr  = par_rdata;
          state_next = S_GRAND;
        end
      end
      S_GRAND: begin
        par_we     = 1'b1;
        par_waddr  = cur;
        par_wdata  = par_rdata;
        cur_next   = par_rdata;
        par_raddr  = par_rdata;
        state_next = S_PAR;
      end
      S_RANK: begin
        state_next = S_JOIN;
      end
      S_JOIN: begin
        if (join_go) begin
          if (!joined) begin
            par_we = 1'b1;
            if (rank_rdata > rank_b) begin
              par_waddr = rb;
              par_wdata = ra;
            end else if (rank_b > rank_rdata) begin
              par_waddr = ra;
              par_wdata = rb;
            end else begin
              par_waddr  = rb;
              par_wdata  = ra;
              rank_we    = (rank_rdata != RANK_MAX);
              rank_waddr = ra;
              rank_wdata = rank_rdata + RANK_W'(1);
            end
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    a_work <= a_work_next;
    b_work <= b_work_next;
    cur    <= cur_next;
    ra     <= ra_next;
    rb     <= rb_next;
    phase  <= phase_next;
    if (state == S_RANK) begin
      rank_b <= rank_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

  ufc_tally u_tally (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .upd         (join_go),
    .joined      (joined),
    .res         (res)
  );

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (join_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (join_go) begin
      already_joined <= res.already_joined;
      cycle_seen     <= res.cycle_seen;
      is_tree        <= res.is_tree;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted edge keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a transfer");

  // A new result only appears from the join step
  a_result_from_join: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_JOIN)
    else $error("result raised outside the join step");

  // Path halving never relinks a node onto itself: the forest stays acyclic
  a_halving_moves: assert property (@(posedge clk) disable iff (rst)
    state == S_GRAND |-> par_rdata != cur)
    else $error("grandparent equals the node being relinked");

  // A spanning tree is never reported alongside a cycle
  a_tree_no_cycle: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_tree |-> !cycle_seen)
    else $error("tree flagged with cycle seen");
`endif

endmodule
